>>> design/rpa_pkg.sv
// Shared types and constants for the relay PID autotune block.
package rpa_pkg;

    // Field widths
    localparam int unsigned YAW_W      = 16;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned DRIVE_W    = 17;
    localparam int unsigned GAIN_W     = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned DUR_W      = 20;
    localparam int unsigned POWER_W    = 16;
    localparam int unsigned DEADBAND_W = 15;
    localparam int unsigned PEAK_W     = 15;
    localparam int unsigned AMP_W      = 23;

    // Arithmetic constants
    localparam logic [POWER_W-1:0] FULL_POWER = 16'd32768;
    localparam logic [29:0]        PI_Q28     = 30'd843314857;
    localparam logic [AMP_W-1:0]   AMP_MAX    = 23'h7FFFFF;
    localparam logic [9:0]         KI_SCALE   = 10'd1000;
    localparam logic [11:0]        KD_SCALE   = 12'd4000;

    // Reset values of the configuration registers
    localparam logic [DUR_W-1:0]      RST_MAX_DURATION = 20'd10000;
    localparam logic [POWER_W-1:0]    RST_RELAY_POWER  = 16'd16384;
    localparam logic [DEADBAND_W-1:0] RST_DEADBAND     = 15'd1920;
    localparam logic [COUNT_W-1:0]    RST_TARGET_HALF  = 8'd10;

    // Shared divider geometry
    localparam int unsigned DIV_DVD_W = 72;
    localparam int unsigned DIV_DSR_W = 64;
    localparam int unsigned DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'(DIV_DVD_W);

    // Input item codes
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DURATION = 2'd0,
        CFG_RELAY_POWER  = 2'd1,
        CFG_DEADBAND     = 2'd2,
        CFG_TARGET_HALF  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> design/rpa_if.sv
// Channel interfaces: sample input, result output and configuration write.
interface rpa_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic signed [rpa_pkg::YAW_W-1:0] yaw;
    logic [rpa_pkg::TICK_W-1:0]     tick_ms;

    modport source (output valid, mode, yaw, tick_ms, input ready);
    modport sink   (input valid, mode, yaw, tick_ms, output ready);
endinterface

interface rpa_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpa_pkg::DRIVE_W-1:0] left_drive;
    logic signed [rpa_pkg::DRIVE_W-1:0] right_drive;
    logic                               finished;
    logic                               gains_valid;
    logic [rpa_pkg::GAIN_W-1:0]         tuned_kp;
    logic [rpa_pkg::GAIN_W-1:0]         tuned_ki;
    logic [rpa_pkg::GAIN_W-1:0]         tuned_kd;
    logic [rpa_pkg::COUNT_W-1:0]        half_cycle_count;

    modport source (output valid, left_drive, right_drive, finished, gains_valid,
                    tuned_kp, tuned_ki, tuned_kd, half_cycle_count, input ready);
    modport sink   (input valid, left_drive, right_drive, finished, gains_valid,
                    tuned_kp, tuned_ki, tuned_kd, half_cycle_count, output ready);
endinterface

interface rpa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rpa_pkg::CFG_IDX_W-1:0]   index;
    logic [rpa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/relay_pid_autotune.sv
// Top level of the relay PID autotune block.
// Relay autotune over yaw samples in degrees/128. A start item (mode 0) latches
// target heading and start time; each sample (mode 1) that falls in a run and
// does not end it updates the peak error, runs the hysteresis relay and returns
// motor drive. Every item yields exactly one result. The sample that ends a run
// with a usable oscillation makes three passes through the shared restoring
// divider (Kp, Ki, Kd) plus six multiply steps on one shared 32x32 multiplier.
// The input is not ready while an item is in work; a finished result may wait
// in the output register meanwhile.
// Configuration writes are always taken and must be made while idle.
module relay_pid_autotune (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpa_in_if.sink    i_in,
    rpa_cfg_if.sink   i_cfg,
    rpa_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_RELAY, S_MUL_PN, S_MUL_DEN, S_DIV_KP, S_MUL_K1, S_MUL_KI,
        S_DIV_KI, S_MUL_K2, S_MUL_KD, S_DIV_KD, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [rpa_pkg::DUR_W-1:0]      r_max_dur;
    logic [rpa_pkg::POWER_W-1:0]    r_power;
    logic [rpa_pkg::DEADBAND_W-1:0] r_deadband;
    logic [rpa_pkg::COUNT_W-1:0]    r_target_half;

    // Run state
    logic [rpa_pkg::YAW_W-1:0]    r_target;
    logic [rpa_pkg::TICK_W-1:0]   r_run_start;
    logic [rpa_pkg::TICK_W-1:0]   r_last_flip;
    logic [rpa_pkg::PEAK_W-1:0]   r_peak;
    logic [rpa_pkg::AMP_W-1:0]    r_amp;
    logic [rpa_pkg::TICK_W-1:0]   r_hpt;
    logic [rpa_pkg::COUNT_W-1:0]  r_half_cycles;
    logic                         r_relay_high;
    logic                         r_first_seen;
    logic                         r_running;

    // Item in work
    logic [rpa_pkg::YAW_W-1:0]    r_yaw;
    logic [rpa_pkg::TICK_W-1:0]   r_tick;
    logic signed [rpa_pkg::YAW_W-1:0] r_err;
    logic [rpa_pkg::PEAK_W-1:0]   r_abs_err;

    // Gain datapath
    logic [63:0]                  r_prod;
    logic [24:0]                  r_num;
    logic [19:0]                  r_k;
    logic [rpa_pkg::GAIN_W-1:0]   r_kp;
    logic                         r_div_go;

    // Pending result
    logic signed [rpa_pkg::DRIVE_W-1:0] r_res_left;
    logic signed [rpa_pkg::DRIVE_W-1:0] r_res_right;
    logic                               r_res_fin;
    logic                               r_res_gv;
    logic [rpa_pkg::GAIN_W-1:0]         r_res_kp;
    logic [rpa_pkg::GAIN_W-1:0]         r_res_ki;
    logic [rpa_pkg::GAIN_W-1:0]         r_res_kd;

    // Output register
    logic                               r_out_valid;
    logic signed [rpa_pkg::DRIVE_W-1:0] r_out_left;
    logic signed [rpa_pkg::DRIVE_W-1:0] r_out_right;
    logic                               r_out_fin;
    logic                               r_out_gv;
    logic [rpa_pkg::GAIN_W-1:0]         r_out_kp;
    logic [rpa_pkg::GAIN_W-1:0]         r_out_ki;
    logic [rpa_pkg::GAIN_W-1:0]         r_out_kd;
    logic [rpa_pkg::COUNT_W-1:0]        r_out_count;

    rpa_pkg::t_div_req div_req;
    rpa_pkg::t_div_rsp div_rsp;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [rpa_pkg::POWER_W-1:0]        power;
    logic signed [rpa_pkg::DRIVE_W-1:0] drive_pos;
    logic signed [rpa_pkg::DRIVE_W-1:0] drive_neg;
    logic [rpa_pkg::TICK_W-1:0]         elapsed;
    logic                               run_over;
    logic                               no_gains;
    logic signed [17:0]                 err_diff;
    logic signed [17:0]                 err_wrap;
    logic signed [17:0]                 err_mod;
    logic signed [rpa_pkg::YAW_W-1:0]   err_val;
    logic [rpa_pkg::PEAK_W-1:0]         peak_new;
    logic signed [16:0]                 err_ext;
    logic signed [16:0]                 db_ext;
    logic                               flip_low;
    logic                               flip_high;
    logic [rpa_pkg::AMP_W:0]            amp_sum;
    logic                               out_free;
    logic [25:0]                        five_amp;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;

    // Relay power clipped to full scale
    always_comb begin
        power     = (r_power > rpa_pkg::FULL_POWER) ? rpa_pkg::FULL_POWER : r_power;
        drive_pos = $signed({1'b0, power});
        drive_neg = -drive_pos;
    end

    // End-of-run check
    always_comb begin
        elapsed  = r_tick - r_run_start;
        run_over = (elapsed >= rpa_pkg::TICK_W'(r_max_dur)) ||
                   (r_half_cycles >= r_target_half);
        no_gains = (r_half_cycles == '0) || (r_amp == '0) || (r_hpt == '0);
    end

    // Heading error wrapped into half a turn either way
    always_comb begin
        err_diff = $signed({{2{r_target[15]}}, r_target}) - $signed({{2{r_yaw[15]}}, r_yaw});
        err_wrap = err_diff + 18'sd23040;
        if (err_wrap < 18'sd0) begin
            err_mod = err_wrap + 18'sd46080;
        end else if (err_wrap >= 18'sd46080) begin
            err_mod = err_wrap - 18'sd46080;
        end else begin
            err_mod = err_wrap;
        end
        err_val = rpa_pkg::YAW_W'(err_mod - 18'sd23040);
    end

    // Relay hysteresis and peak tracking
    always_comb begin
        peak_new  = (r_abs_err > r_peak) ? r_abs_err : r_peak;
        err_ext   = {r_err[15], r_err};
        db_ext    = $signed({2'b00, r_deadband});
        flip_low  = r_relay_high && (err_ext < -db_ext);
        flip_high = !r_relay_high && (err_ext > db_ext);
        amp_sum   = {1'b0, r_amp} + (rpa_pkg::AMP_W+1)'(peak_new);
    end

    // Shared multiplier operand selection
    always_comb begin
        five_amp = {1'b0, r_amp, 2'b00} + {3'b000, r_amp};
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL_PN: begin
                mul_a = 32'(power);
                mul_b = 32'(r_half_cycles);
            end
            S_MUL_DEN: begin
                mul_a = 32'(five_amp);
                mul_b = 32'(rpa_pkg::PI_Q28);
            end
            S_MUL_K1: begin
                mul_a = 32'(rpa_pkg::KI_SCALE);
                mul_b = 32'(r_half_cycles);
            end
            S_MUL_K2: begin
                mul_a = 32'(rpa_pkg::KD_SCALE);
                mul_b = 32'(r_half_cycles);
            end
            S_MUL_KI: begin
                mul_a = r_kp;
                mul_b = 32'(r_k);
            end
            S_MUL_KD: begin
                mul_a = r_kp;
                mul_b = r_hpt;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Divider request
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {8'd0, r_prod};
        div_req.divisor  = '0;
        unique case (r_state)
            S_DIV_KP: begin
                div_req.start    = !r_div_go;
                div_req.dividend = {1'b0, r_num, 46'd0};
                div_req.divisor  = r_prod;
            end
            S_DIV_KI: begin
                div_req.start   = !r_div_go;
                div_req.divisor = 64'(r_hpt);
            end
            S_DIV_KD: begin
                div_req.start   = !r_div_go;
                div_req.divisor = 64'(r_k);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    rpa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dur     <= rpa_pkg::RST_MAX_DURATION;
            r_power       <= rpa_pkg::RST_RELAY_POWER;
            r_deadband    <= rpa_pkg::RST_DEADBAND;
            r_target_half <= rpa_pkg::RST_TARGET_HALF;
        end else if (i_cfg.valid) begin
            unique case (rpa_pkg::t_cfg_idx'(i_cfg.index))
                rpa_pkg::CFG_MAX_DURATION: r_max_dur     <= i_cfg.data;
                rpa_pkg::CFG_RELAY_POWER:  r_power       <= i_cfg.data[rpa_pkg::POWER_W-1:0];
                rpa_pkg::CFG_DEADBAND:     r_deadband    <= i_cfg.data[rpa_pkg::DEADBAND_W-1:0];
                rpa_pkg::CFG_TARGET_HALF:  r_target_half <= i_cfg.data[rpa_pkg::COUNT_W-1:0];
                default:                   r_max_dur     <= r_max_dur;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_target      <= '0;
            r_run_start   <= '0;
            r_last_flip   <= '0;
            r_peak        <= '0;
            r_amp         <= '0;
            r_hpt         <= '0;
            r_half_cycles <= '0;
            r_relay_high  <= 1'b1;
            r_first_seen  <= 1'b0;
            r_running     <= 1'b0;
            r_div_go      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // S_OUT reloads the slot itself when it hands over a result
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_res_left  <= '0;
                    r_res_right <= '0;
                    r_res_fin   <= 1'b0;
                    r_res_gv    <= 1'b0;
                    r_res_kp    <= '0;
                    r_res_ki    <= '0;
                    r_res_kd    <= '0;
                    if (i_in.valid) begin
                        r_yaw  <= i_in.yaw;
                        r_tick <= i_in.tick_ms;
                        if (i_in.mode == rpa_pkg::MODE_START) begin
                            r_target      <= i_in.yaw;
                            r_run_start   <= i_in.tick_ms;
                            r_last_flip   <= i_in.tick_ms;
                            r_peak        <= '0;
                            r_amp         <= '0;
                            r_hpt         <= '0;
                            r_half_cycles <= '0;
                            r_relay_high  <= 1'b1;
                            r_first_seen  <= 1'b0;
                            r_running     <= 1'b1;
                            r_state       <= S_OUT;
                        end else if (!r_running) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ERR;
                        end
                    end
                end
                S_ERR: begin
                    if (run_over) begin
                        r_running <= 1'b0;
                        r_res_fin <= 1'b1;
                        r_state   <= no_gains ? S_OUT : S_MUL_PN;
                    end else begin
                        r_err     <= err_val;
                        r_abs_err <= rpa_pkg::PEAK_W'(err_val[15] ? -err_val : err_val);
                        r_state   <= S_RELAY;
                    end
                end
                S_RELAY: begin
                    if (flip_low || flip_high) begin
                        r_relay_high <= flip_high;
                        if (r_first_seen) begin
                            r_hpt <= r_hpt + (r_tick - r_last_flip);
                            r_amp <= amp_sum[rpa_pkg::AMP_W] ? rpa_pkg::AMP_MAX
                                                             : amp_sum[rpa_pkg::AMP_W-1:0];
                            if (r_half_cycles != '1) begin
                                r_half_cycles <= r_half_cycles + 1'b1;
                            end
                        end
                        r_first_seen <= 1'b1;
                        r_last_flip  <= r_tick;
                        r_peak       <= '0;
                    end else begin
                        r_peak <= peak_new;
                    end
                    // relay high drives left back and right forward
                    if (flip_high || (r_relay_high && !flip_low)) begin
                        r_res_left  <= drive_neg;
                        r_res_right <= drive_pos;
                    end else begin
                        r_res_left  <= drive_pos;
                        r_res_right <= drive_neg;
                    end
                    r_state <= S_OUT;
                end
                S_MUL_PN: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_DEN;
                end
                S_MUL_DEN: begin
                    r_num   <= {1'b0, r_prod[22:0], 1'b0} + {2'b00, r_prod[22:0]};
                    r_prod  <= mul_p;
                    r_state <= S_DIV_KP;
                end
                S_DIV_KP: begin
                    r_div_go <= 1'b1;
                    if (div_rsp.done) begin
                        r_div_go <= 1'b0;
                        r_kp     <= div_rsp.quotient;
                        r_res_kp <= div_rsp.quotient;
                        r_state  <= S_MUL_K1;
                    end
                end
                S_MUL_K1: begin
                    r_k     <= mul_p[19:0];
                    r_state <= S_MUL_KI;
                end
                S_MUL_KI: begin
                    r_prod  <= mul_p;
                    r_state <= S_DIV_KI;
                end
                S_DIV_KI: begin
                    r_div_go <= 1'b1;
                    if (div_rsp.done) begin
                        r_div_go <= 1'b0;
                        r_res_ki <= div_rsp.quotient;
                        r_state  <= S_MUL_K2;
                    end
                end
                S_MUL_K2: begin
                    r_k     <= mul_p[19:0];
                    r_state <= S_MUL_KD;
                end
                S_MUL_KD: begin
                    r_prod  <= mul_p;
                    r_state <= S_DIV_KD;
                end
                S_DIV_KD: begin
                    r_div_go <= 1'b1;
                    if (div_rsp.done) begin
                        r_div_go <= 1'b0;
                        r_res_kd <= div_rsp.quotient;
                        r_res_gv <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hand the result over once the output slot frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= r_res_left;
                        r_out_right <= r_res_right;
                        r_out_fin   <= r_res_fin;
                        r_out_gv    <= r_res_gv;
                        r_out_kp    <= r_res_kp;
                        r_out_ki    <= r_res_ki;
                        r_out_kd    <= r_res_kd;
                        r_out_count <= r_half_cycles;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.left_drive       = r_out_left;
    assign o_out.right_drive      = r_out_right;
    assign o_out.finished         = r_out_fin;
    assign o_out.gains_valid      = r_out_gv;
    assign o_out.tuned_kp         = r_out_kp;
    assign o_out.tuned_ki         = r_out_ki;
    assign o_out.tuned_kd         = r_out_kd;
    assign o_out.half_cycle_count = r_out_count;

endmodule

>>> design/rpa_divider.sv
// Restoring radix-2 divider with a 32-bit saturating quotient.
module rpa_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpa_pkg::t_div_req i_req,
    output rpa_pkg::t_div_rsp o_rsp
);
    logic                          r_busy;
    logic                          r_done;
    logic [rpa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [rpa_pkg::DIV_DVD_W-1:0] r_dvd;
    logic [rpa_pkg::DIV_DSR_W-1:0] r_dsr;
    logic [rpa_pkg::DIV_DSR_W-1:0] r_rem;
    logic [rpa_pkg::GAIN_W-1:0]    r_q;
    logic                          r_sat;

    logic [rpa_pkg::DIV_DSR_W:0]   rem_sh;
    logic                          fits;

    // One quotient bit per cycle while busy
    always_comb begin
        rem_sh = {r_rem, r_dvd[rpa_pkg::DIV_DVD_W-1]};
        fits   = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= rpa_pkg::DIV_STEPS;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[rpa_pkg::DIV_DVD_W-2:0], 1'b0};
                if (fits) begin
                    r_rem <= rpa_pkg::DIV_DSR_W'(rem_sh - {1'b0, r_dsr});
                end else begin
                    r_rem <= rem_sh[rpa_pkg::DIV_DSR_W-1:0];
                end
                // a bit pushed past bit 31 means the quotient saturates
                r_sat <= r_sat | r_q[rpa_pkg::GAIN_W-1];
                r_q   <= {r_q[rpa_pkg::GAIN_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rpa_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_sat ? '1 : r_q;

endmodule

>>> design/rpa_checker.sv
// Port-level assertions for the relay PID autotune block and their binding.
module rpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_finished,
    input logic        i_gains_valid,
    input logic [16:0] i_left,
    input logic [16:0] i_right,
    input logic [31:0] i_kp,
    input logic [31:0] i_ki,
    input logic [31:0] i_kd
);
    // A finished result carries no drive
    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished |-> i_left == '0 && i_right == '0)
        else $error("drive not zero on finished result");

    // Gains only come with the result that ends a run
    a_gv_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_gains_valid |-> i_finished)
        else $error("gains valid without finished");

    // Gains read zero unless valid
    a_gains_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_gains_valid |-> i_kp == '0 && i_ki == '0 && i_kd == '0)
        else $error("nonzero gains while not valid");

    // After an input transfer the block is not ready in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A waiting result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");
endmodule

bind relay_pid_autotune rpa_checker u_rpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_finished   (o_out.finished),
    .i_gains_valid(o_out.gains_valid),
    .i_left       (o_out.left_drive),
    .i_right      (o_out.right_drive),
    .i_kp         (o_out.tuned_kp),
    .i_ki         (o_out.tuned_ki),
    .i_kd         (o_out.tuned_kd)
);
